### hdl/alt_pkg.sv
// Package for the alias table sampler.
// Holds controller state codes, status, kind and action codes, default sizes and the divider control struct.
// No dependencies.
`default_nettype none
package alt_pkg;
    localparam int unsigned MAX_ENTRIES_DEF = 1024;
    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned IDX_W           = 10;
    localparam int unsigned ST_W            = 2;
    localparam int unsigned RAND_W          = 16;
    localparam int unsigned WGT_W           = 32;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO    = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERRUN = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTABLE = 2'd3;

    localparam logic KIND_BUILD  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_SAMPLE  = 1'b1;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_CHECK = 20'h00002,
        S_SRD   = 20'h00004,
        S_SMUL  = 20'h00008,
        S_SDST  = 20'h00010,
        S_SDIV  = 20'h00020,
        S_PRD   = 20'h00040,
        S_PPUSH = 20'h00080,
        S_POP1  = 20'h00100,
        S_POP2  = 20'h00200,
        S_POP3  = 20'h00400,
        S_POP4  = 20'h00800,
        S_POP5  = 20'h01000,
        S_LRD   = 20'h02000,
        S_LWR   = 20'h04000,
        S_SAMP  = 20'h08000,
        S_SPICK = 20'h10000,
        S_OUT   = 20'h20000,
        S_SWR   = 20'h40000,
        S_SPARE = 20'h80000
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

### hdl/alt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses alt_pkg for the control struct.
`default_nettype none
module alt_div
    import alt_pkg::*;
#(
    parameter int unsigned NW = 66,
    parameter int unsigned DW = 43
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output t_div_ctl           o_ctl,
    output logic      [NW-1:0] o_quo
);
    localparam int unsigned CNW = $clog2(NW + 1);

    logic [DW-1:0]  r_rem, n_rem;
    logic [NW-1:0]  r_quo, n_quo;
    logic [DW-1:0]  r_den, n_den;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [DW:0]    trial;
    logic [DW:0]    diff;

    always_comb begin
        trial  = {r_rem, r_quo[NW-1]};
        diff   = trial - {1'b0, r_den};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = diff[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quo       = r_quo;
endmodule
`default_nettype wire

### hdl/alias_table_sampler.sv
// Top level of the alias table sampler: controller, entry and stack memories.
// Depends on alt_pkg and alt_div.
//
// Usage:
//  Input stream (s side): tuser = action (0 load, 1 sample), tlast = last weight,
//  tdata = {rand_b, rand_a, weight}. Loads append one weight each; the load with
//  tlast set starts the table build. Samples return one index.
//  Output stream (m side): tuser = kind (0 build done, 1 sample answer),
//  tdata = {4'b0, status, index}.
//  A load without tlast leaves the controller idle, ready for the next input. A
//  sample passes through column multiply and entry read, pick, and output load.
//  The build is dominated by the bit-serial divider that scales each weight,
//  NW = 32 + clog2(MAX_ENTRIES+1) + FRAC_BITS bits wide.
//  Input is taken only while the controller is idle; a finished result sits in
//  the output register, so loads keep flowing while the receiver stalls, and the
//  next result waits in its output state until the register frees up.
//  Reset clears counts, flags and the output valid; memories are not cleared,
//  every build reads only entries it wrote itself.
`default_nettype none
module alias_table_sampler
    import alt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,  // weight[31:0], rand_a[47:32], rand_b[63:48]
    input  wire logic        i_s_tlast,
    input  wire logic        i_s_tuser,  // action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,  // index[9:0], status[11:10], zeros above
    output logic             o_m_tuser   // kind
);
    localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SW  = WGT_W + CW;
    localparam int unsigned PW  = CW + FRAC_BITS;
    localparam int unsigned VW  = (PW > WGT_W) ? PW : WGT_W;
    localparam int unsigned NW  = SW + FRAC_BITS;
    localparam int unsigned AC  = FRAC_BITS + 1;
    localparam int unsigned EW  = AW + AC + VW;
    localparam int unsigned IW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int unsigned CMW = FRAC_BITS + RAND_W + 1;
    localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
    localparam logic [AC-1:0] ONE_A = AC'(1) << FRAC_BITS;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    // entry record: {alias, accept, value}
    logic [EW-1:0] ent_mem [MAX_ENTRIES];
    logic [AW-1:0] stk_mem [MAX_ENTRIES];

    logic          e_we, e_re, s_we, s_re;
    logic [AW-1:0] e_waddr, e_raddr, s_waddr, s_raddr, s_wdata;
    logic [EW-1:0] e_wdata;
    logic [EW-1:0] r_erd;
    logic [AW-1:0] r_srd;

    always_ff @(posedge i_clk) begin
        if (e_we) ent_mem[e_waddr] <= e_wdata;
        if (e_re) r_erd <= ent_mem[e_raddr];
        if (s_we) stk_mem[s_waddr] <= s_wdata;
        if (s_re) r_srd <= stk_mem[s_raddr];
    end

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt, r_k, n_k, r_ns, n_ns, r_nl, n_nl;
    logic [SW-1:0]       r_sum, n_sum;
    logic                r_ready, n_ready, r_ovf, n_ovf, r_fresh, n_fresh;
    logic [SW-1:0]       r_prod, n_prod;
    logic [AW-1:0]       r_s, n_s, r_l, n_l;
    logic [VW-1:0]       r_ps, n_ps, r_pl, n_pl;
    logic [RAND_W-1:0]   r_ra, n_ra, r_rb, n_rb;
    logic                r_ovalid, n_ovalid, r_okind, n_okind, r_pkind, n_pkind;
    logic [IDX_W-1:0]    r_oidx, n_oidx, r_pidx, n_pidx;
    logic [ST_W-1:0]     r_ostat, n_ostat, r_pstat, n_pstat;

    t_div_ctl            div_ctl;
    logic [NW-1:0]       div_quo;
    logic                div_start;

    alt_div #(
        .NW (NW),
        .DW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_prod, {FRAC_BITS{1'b0}}}),
        .i_den   (r_sum),
        .o_ctl   (div_ctl),
        .o_quo   (div_quo)
    );

    logic                 s_acc;
    logic [CW-1:0]        cnt_e;
    logic [SW-1:0]        sum_e;
    logic                 ovf_e;
    logic [CW+RAND_W-1:0] col_mul;
    logic [VW-1:0]        erd_val, ps_val;
    logic [AC-1:0]        erd_acc;
    logic [AW-1:0]        erd_ali;
    logic [CMW-1:0]       cmp_l, cmp_r;
    logic [IW-1:0]        pick_ext;
    logic [CW-1:0]        ltop;
    logic                 out_free;

    assign erd_val  = r_erd[VW-1:0];
    assign erd_acc  = r_erd[VW+AC-1:VW];
    assign erd_ali  = r_erd[EW-1:VW+AC];
    assign col_mul  = r_cnt * r_ra;
    assign cmp_l    = CMW'({r_rb, {FRAC_BITS{1'b0}}});
    assign cmp_r    = CMW'({erd_acc, {RAND_W{1'b0}}});
    assign ltop     = MAX_C - r_nl;
    assign out_free = !r_ovalid || i_m_tready;
    assign ps_val   = r_ps;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_k = r_k;  n_ns = r_ns;  n_nl = r_nl;
        n_sum = r_sum;  n_ready = r_ready;  n_ovf = r_ovf;  n_fresh = r_fresh;
        n_prod = r_prod;  n_s = r_s;  n_l = r_l;  n_ps = r_ps;  n_pl = r_pl;
        n_ra = r_ra;  n_rb = r_rb;
        n_pkind = r_pkind;  n_pidx = r_pidx;  n_pstat = r_pstat;
        n_ovalid = r_ovalid && !i_m_tready;
        n_okind = r_okind;  n_oidx = r_oidx;  n_ostat = r_ostat;
        e_we = 1'b0;  e_re = 1'b0;  s_we = 1'b0;  s_re = 1'b0;
        e_waddr = '0;  e_raddr = '0;  e_wdata = '0;
        s_waddr = '0;  s_raddr = '0;  s_wdata = '0;
        div_start = 1'b0;
        pick_ext = '0;
        cnt_e = r_fresh ? '0 : r_cnt;
        sum_e = r_fresh ? '0 : r_sum;
        ovf_e = r_fresh ? 1'b0 : r_ovf;

        case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tuser == ACT_LOAD) begin
                    n_fresh = 1'b0;
                    n_ready = 1'b0;
                    if (cnt_e < MAX_C) begin
                        e_we    = 1'b1;
                        e_waddr = cnt_e[AW-1:0];
                        e_wdata = EW'(i_s_tdata[WGT_W-1:0]);
                        n_cnt   = cnt_e + 1'b1;
                        n_sum   = sum_e + SW'(i_s_tdata[WGT_W-1:0]);
                        n_ovf   = ovf_e;
                    end else begin
                        n_cnt = cnt_e;
                        n_sum = sum_e;
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_fresh = 1'b1;
                        n_state = S_CHECK;
                    end
                end else if (s_acc) begin
                    n_ra = i_s_tdata[47:32];
                    n_rb = i_s_tdata[63:48];
                    if (!r_ready || r_cnt == '0) begin
                        n_pkind = KIND_SAMPLE;
                        n_pidx  = '0;
                        n_pstat = ST_NOTABLE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SAMP;
                    end
                end
            end
            S_CHECK: begin
                n_pkind = KIND_BUILD;
                n_pidx  = '0;
                n_k     = '0;
                if (r_ovf) begin
                    n_pstat = ST_OVERRUN;
                    n_state = S_OUT;
                end else if (r_sum == '0 || r_cnt == '0) begin
                    n_pstat = ST_ZERO;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                e_re    = 1'b1;
                e_raddr = r_k[AW-1:0];
                n_state = S_SMUL;
            end
            S_SMUL: begin
                n_prod  = SW'(erd_val[WGT_W-1:0] * r_cnt);
                n_state = S_SDST;
            end
            S_SDST: begin
                div_start = 1'b1;
                n_state   = S_SDIV;
            end
            S_SDIV: begin
                if (div_ctl.done) n_state = S_SWR;
            end
            S_SWR: begin
                e_we    = 1'b1;
                e_waddr = r_k[AW-1:0];
                e_wdata = EW'(div_quo[PW-1:0]);
                if (r_k + 1'b1 == r_cnt) begin
                    n_k     = r_cnt - 1'b1;
                    n_ns    = '0;
                    n_nl    = '0;
                    n_state = S_PRD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_PRD: begin
                e_re    = 1'b1;
                e_raddr = r_k[AW-1:0];
                n_state = S_PPUSH;
            end
            S_PPUSH: begin
                s_we    = 1'b1;
                s_wdata = r_k[AW-1:0];
                if (erd_val < ONE_V) begin
                    s_waddr = r_ns[AW-1:0];
                    n_ns    = r_ns + 1'b1;
                end else begin
                    s_waddr = AW'(ltop - 1'b1);
                    n_nl    = r_nl + 1'b1;
                end
                if (r_k == '0) begin
                    n_state = S_POP1;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = S_PRD;
                end
            end
            S_POP1: begin
                if (r_ns == '0 || r_nl == '0) begin
                    n_state = S_LRD;
                end else begin
                    s_re    = 1'b1;
                    s_raddr = AW'(r_ns - 1'b1);
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                n_s     = r_srd;
                e_re    = 1'b1;
                e_raddr = r_srd;
                s_re    = 1'b1;
                s_raddr = ltop[AW-1:0];
                n_state = S_POP3;
            end
            S_POP3: begin
                n_l     = r_srd;
                n_ps    = erd_val;
                e_re    = 1'b1;
                e_raddr = r_srd;
                n_state = S_POP4;
            end
            S_POP4: begin
                e_we    = 1'b1;
                e_waddr = r_s;
                e_wdata = {r_l, ps_val[AC-1:0], ps_val};
                n_pl    = erd_val + r_ps - ONE_V;
                n_state = S_POP5;
            end
            S_POP5: begin
                e_we    = 1'b1;
                e_waddr = r_l;
                e_wdata = EW'(r_pl);
                s_we    = 1'b1;
                s_wdata = r_l;
                if (r_pl < ONE_V) begin
                    s_waddr = AW'(r_ns - 1'b1);
                    n_nl    = r_nl - 1'b1;
                end else begin
                    s_waddr = ltop[AW-1:0];
                    n_ns    = r_ns - 1'b1;
                end
                n_state = S_POP1;
            end
            S_LRD: begin
                if (r_nl != '0) begin
                    s_re    = 1'b1;
                    s_raddr = ltop[AW-1:0];
                    n_nl    = r_nl - 1'b1;
                    n_state = S_LWR;
                end else if (r_ns != '0) begin
                    s_re    = 1'b1;
                    s_raddr = AW'(r_ns - 1'b1);
                    n_ns    = r_ns - 1'b1;
                    n_state = S_LWR;
                end else begin
                    n_ready = 1'b1;
                    n_pstat = ST_OK;
                    n_state = S_OUT;
                end
            end
            S_LWR: begin
                e_we    = 1'b1;
                e_waddr = r_srd;
                e_wdata = {r_srd, ONE_A, {VW{1'b0}}};
                n_state = S_LRD;
            end
            S_SAMP: begin
                e_re    = 1'b1;
                e_raddr = col_mul[RAND_W+AW-1:RAND_W];
                n_s     = col_mul[RAND_W+AW-1:RAND_W];
                n_state = S_SPICK;
            end
            S_SPICK: begin
                pick_ext = (cmp_l < cmp_r) ? IW'(r_s) : IW'(erd_ali);
                n_pkind  = KIND_SAMPLE;
                n_pidx   = pick_ext[IDX_W-1:0];
                n_pstat  = ST_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_pkind;
                    n_oidx   = r_pidx;
                    n_ostat  = r_pstat;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_ready  <= 1'b0;
            r_ovf    <= 1'b0;
            r_fresh  <= 1'b1;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_ns     <= '0;
            r_nl     <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_ready  <= n_ready;
            r_ovf    <= n_ovf;
            r_fresh  <= n_fresh;
            r_ovalid <= n_ovalid;
            r_k      <= n_k;
            r_ns     <= n_ns;
            r_nl     <= n_nl;
        end
        r_prod  <= n_prod;
        r_s     <= n_s;
        r_l     <= n_l;
        r_ps    <= n_ps;
        r_pl    <= n_pl;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_okind <= n_okind;
        r_oidx  <= n_oidx;
        r_ostat <= n_ostat;
        r_pkind <= n_pkind;
        r_pidx  <= n_pidx;
        r_pstat <= n_pstat;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tdata  = {4'b0000, r_ostat, r_oidx};

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_IDLE)
        else $error("controller not idle after reset");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_C)
        else $error("entry count beyond table size");
    a_stk_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP1 || r_state == S_LRD) |-> (r_ns + r_nl) <= r_cnt)
        else $error("stacks hold more than the entry count");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !div_ctl.busy)
        else $error("divider busy while idle");
    a_ready_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> r_state == S_OUT && r_pstat == ST_OK)
        else $error("table marked ready outside a good build");
endmodule
`default_nettype wire

### tb/tb_alias_table_sampler.sv
// Testbench for alias_table_sampler: table loads, builds and sample queries.
// A directed table, then random load/sample traffic, checked against an in-bench predictor.
// Depends on alt_pkg and the alias_table_sampler RTL.
`timescale 1ns / 1ps
module tb_alias_table_sampler;
    import alt_pkg::*;

    localparam int unsigned NMAX = MAX_ENTRIES_DEF;
    localparam int unsigned FB   = FRAC_BITS_DEF;

    typedef struct packed {
        logic        action;
        logic [31:0] weight;
        logic        last;
        logic [15:0] rand_a;
        logic [15:0] rand_b;
    } t_req;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [ST_W-1:0]  status;
    } t_ans;

    // directed row: request plus optional hand-typed answer
    typedef struct packed {
        t_req req;
        logic fixed;
        t_ans ans;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        i_s_tlast;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;

    alias_table_sampler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // predictor state
    logic [31:0]  wt_mem [NMAX];
    logic [63:0]  prob_mem [NMAX];
    logic [16:0]  acc_mem [NMAX];
    logic [9:0]   alias_mem [NMAX];
    int unsigned  n_entries;
    logic [63:0]  wt_total;
    bit           have_table, overrun, new_set;

    t_ans   answer_q[$];
    int     errors;
    bit     quiet;     // true during no-idle stretch
    bit     hold_rx;

    function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [ST_W-1:0] build_alias();
        logic [63:0] unit;
        int unsigned sm[$], lg[$];
        int unsigned s, l;
        unit = 64'd1 << FB;
        if (overrun) return ST_OVERRUN;
        if (wt_total == 0 || n_entries == 0) return ST_ZERO;
        for (int k = 0; k < n_entries; k++)
            prob_mem[k] = frac_div(64'(wt_mem[k]) * n_entries, wt_total);
        for (int k = n_entries - 1; k >= 0; k--) begin
            if (prob_mem[k] < unit) sm.push_back(k);
            else lg.push_back(k);
        end
        while (sm.size() > 0 && lg.size() > 0) begin
            s = sm.pop_back();
            l = lg.pop_back();
            acc_mem[s] = prob_mem[s][16:0];
            alias_mem[s] = l[9:0];
            prob_mem[l] = prob_mem[l] + prob_mem[s] - unit;
            if (prob_mem[l] < unit) sm.push_back(l);
            else lg.push_back(l);
        end
        while (lg.size() > 0) begin
            l = lg.pop_back();
            acc_mem[l] = unit[16:0];
            alias_mem[l] = l[9:0];
        end
        while (sm.size() > 0) begin
            s = sm.pop_back();
            acc_mem[s] = unit[16:0];
            alias_mem[s] = s[9:0];
        end
        return ST_OK;
    endfunction

    // returns 1 when the item yields an answer
    function automatic bit predict_item(t_req r, output t_ans a);
        logic [31:0] col;
        a = '0;
        if (r.action == ACT_LOAD) begin
            if (new_set) begin
                n_entries = 0;
                wt_total = 0;
                overrun = 0;
                have_table = 0;
                new_set = 0;
            end
            if (n_entries < NMAX) begin
                wt_mem[n_entries] = r.weight;
                n_entries++;
                wt_total += r.weight;
            end else begin
                overrun = 1;
            end
            if (!r.last) return 0;
            a.kind = KIND_BUILD;
            a.status = build_alias();
            have_table = (a.status == ST_OK);
            new_set = 1;
            return 1;
        end
        a.kind = KIND_SAMPLE;
        if (!have_table || n_entries == 0) begin
            a.status = ST_NOTABLE;
            return 1;
        end
        col = (n_entries * r.rand_a) >> 16;
        if (col >= n_entries) col = n_entries - 1;
        if ((64'(r.rand_b) << FB) < (64'(acc_mem[col]) << 16)) a.index = col[9:0];
        else a.index = alias_mem[col];
        a.status = ST_OK;
        return 1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[alias_table_sampler] ERROR");
        $finish;
    end

    // receiver: random stalls, compare each answer with oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t unexpected answer kind=%0b data=%h", $time,
                             o_m_tuser, o_m_tdata);
                    errors++;
                end else begin
                    t_ans e;
                    e = answer_q.pop_front();
                    if (o_m_tuser !== e.kind || o_m_tdata[9:0] !== e.index ||
                        o_m_tdata[11:10] !== e.status || o_m_tdata[15:12] !== 4'b0) begin
                        $display("%0t mismatch: expected kind=%0b idx=%0d st=%0d, got kind=%0b idx=%0d st=%0d hi=%h",
                                 $time, e.kind, e.index, e.status, o_m_tuser,
                                 o_m_tdata[9:0], o_m_tdata[11:10], o_m_tdata[15:12]);
                        errors++;
                    end
                end
            end
            i_m_tready <= !hold_rx && (quiet || $urandom_range(99) >= 34);
        end
    end

    // drive one item, with a random idle gap first; valid stays up after accept
    task automatic send_item(t_req r);
        t_ans a;
        while (!quiet && $urandom_range(99) < 34) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.action;
        i_s_tlast  <= r.last;
        i_s_tdata  <= {r.rand_b, r.rand_a, r.weight};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (predict_item(r, a)) answer_q.push_back(a);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_req mk_load(logic [31:0] w, logic l);
        t_req r;
        r = '0;
        r.action = ACT_LOAD;
        r.weight = w;
        r.last = l;
        r.rand_a = 16'($urandom);
        r.rand_b = 16'($urandom);
        return r;
    endfunction

    function automatic t_req mk_sample(logic [15:0] ra, logic [15:0] rb);
        t_req r;
        r = '0;
        r.action = ACT_SAMPLE;
        r.rand_a = ra;
        r.rand_b = rb;
        r.weight = $urandom;
        r.last = $urandom_range(1);
        return r;
    endfunction

    function automatic t_row row(t_req r, bit fx, t_ans a);
        t_row x;
        x.req = r;
        x.fixed = fx;
        x.ans = a;
        return x;
    endfunction

    task automatic random_set(output int unsigned n_sent);
        int unsigned n, mode;
        logic [31:0] w;
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        mode = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: w = $urandom;
                1: w = $urandom_range(9);
                2: w = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1000);
                default: w = $urandom_range(1) ? 32'd0 : $urandom;
            endcase
            send_item(mk_load(w, i == n - 1));
        end
        n_sent = n;
    endtask

    initial begin
        t_row rows[$];
        t_ans a0;
        t_req r;
        int   sent;
        int unsigned got;
        errors = 0;
        quiet = 0;
        hold_rx = 0;
        n_entries = 0;
        wt_total = 0;
        have_table = 0;
        overrun = 0;
        new_set = 1;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sample before any table, zero-sum build, extremes, samples
        a0 = '0;
        rows.push_back(row(mk_sample(16'h0, 16'h0), 1, '{KIND_SAMPLE, 10'd0, ST_NOTABLE}));
        rows.push_back(row(mk_load(32'd0, 1'b1), 1, '{KIND_BUILD, 10'd0, ST_ZERO}));
        rows.push_back(row(mk_sample(16'hFFFF, 16'hFFFF), 1, '{KIND_SAMPLE, 10'd0, ST_NOTABLE}));
        rows.push_back(row(mk_load(32'hFFFF_FFFF, 1'b0), 0, a0));
        rows.push_back(row(mk_load(32'd1, 1'b0), 0, a0));
        rows.push_back(row(mk_load(32'd0, 1'b0), 0, a0));
        rows.push_back(row(mk_load(32'hFFFF_FFFF, 1'b1), 1, '{KIND_BUILD, 10'd0, ST_OK}));
        rows.push_back(row(mk_sample(16'h0000, 16'h0000), 0, a0));
        rows.push_back(row(mk_sample(16'hFFFF, 16'hFFFF), 0, a0));
        rows.push_back(row(mk_sample(16'h8000, 16'hFFFF), 0, a0));
        rows.push_back(row(mk_sample(16'h4000, 16'h0001), 0, a0));
        rows.push_back(row(mk_sample(16'hC000, 16'h7FFF), 0, a0));
        // new load while a table exists: samples go invalid
        rows.push_back(row(mk_load(32'd5, 1'b0), 0, a0));
        rows.push_back(row(mk_sample(16'h1234, 16'h5678), 1, '{KIND_SAMPLE, 10'd0, ST_NOTABLE}));
        rows.push_back(row(mk_load(32'd3, 1'b1), 0, a0));
        rows.push_back(row(mk_sample(16'hAAAA, 16'h5555), 0, a0));
        rows.push_back(row(mk_load(32'd7, 1'b1), 1, '{KIND_BUILD, 10'd0, ST_OK}));
        rows.push_back(row(mk_sample(16'h5555, 16'hAAAA), 1, '{KIND_SAMPLE, 10'd0, ST_OK}));

        foreach (rows[i]) begin
            int n_prior;
            n_prior = answer_q.size();
            send_item(rows[i].req);
            if (rows[i].fixed && answer_q.size() > n_prior &&
                answer_q[answer_q.size()-1] !== rows[i].ans) begin
                $display("%0t directed row %0d: expected %p, predictor %p", $time, i,
                         rows[i].ans, answer_q[answer_q.size()-1]);
                errors++;
            end
        end

        // overflow: one more load than the table holds
        for (int i = 0; i <= NMAX; i++) send_item(mk_load($urandom_range(3), i == NMAX));
        send_item(mk_sample(16'($urandom), 16'($urandom)));

        // sender holds off with the receiver stalled, then the receiver resumes until every answer is back
        i_s_tvalid <= 1'b0;
        hold_rx = 1;
        repeat (30) @(posedge i_clk);
        hold_rx = 0;
        drain();

        // random traffic: well-formed load sets mixed with single samples and stray loads
        sent = 0;
        while (sent < 200) begin
            quiet = (sent > 60 && sent < 130);
            if ($urandom_range(9) < 3) begin
                random_set(got);
                sent += got;
            end else begin
                r = mk_sample(16'($urandom), 16'($urandom));
                if ($urandom_range(15) == 0) r = mk_load($urandom, $urandom_range(1));
                send_item(r);
                sent++;
            end
        end
        quiet = 0;

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("[alias_table_sampler] OK");
        end else begin
            $display("[alias_table_sampler] ERROR");
        end
        $finish;
    end
endmodule
